### design/mmpq_pkg.sv
// Shared types and constants for the min/max priority queue.
package mmpq_pkg;

  localparam int CLIENT_W     = 20;
  localparam int PRIO_W       = 24;
  localparam int OPCODE_W     = 2;
  localparam int STATUS_W     = 3;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_POP_MAX = 2'd1,
    OP_POP_MIN = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_POPPED    = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUPLICATE = 3'd4
  } status_t;

  typedef struct packed {
    logic [CLIENT_W-1:0] client;
    logic [PRIO_W-1:0]   prio;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop_min;
  } cell_cmd_t;

endpackage

### design/min_max_priority_queue_top.sv
// Top level of the min/max priority queue: a sorted row of cells with a result register.
// An input transfer's result is registered and valid in the cycle after the transfer.
// Throughput: one item per cycle if in_ready; all cells compare in parallel, shift once.
// A new item is taken whenever the result register is empty or being drained.
// Reset clears the fill count and the result valid; slot contents stay undefined.
module min_max_priority_queue_top #(
  parameter int CAPACITY = mmpq_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mmpq_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [mmpq_pkg::CLIENT_W-1:0] in_client_id,
  input  logic [mmpq_pkg::PRIO_W-1:0]   in_priority_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mmpq_pkg::STATUS_W-1:0] out_status,
  output logic [mmpq_pkg::CLIENT_W-1:0] out_popped_client,
  output logic [mmpq_pkg::PRIO_W-1:0]   out_popped_priority
);
  import mmpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  status_t             status_r;
  status_t             status_nxt;
  logic [CLIENT_W-1:0] client_r;
  logic [CLIENT_W-1:0] client_nxt;
  logic [PRIO_W-1:0]   prio_r;
  logic [PRIO_W-1:0]   prio_nxt;

  logic                accept;
  logic                dup;
  logic                full;
  logic                empty;
  logic [CNT_W-1:0]    count_m1;
  logic [IDX_W-1:0]    top_idx;
  cell_cmd_t           cmd;
  entry_t              new_entry;

  logic [CAPACITY-1:0] ge_v;
  logic [CAPACITY-1:0] eq_v;
  entry_t              cell_entry [CAPACITY];

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign new_entry = '{client: in_client_id, prio: in_priority_req};

  assign dup      = |eq_v;
  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign count_m1 = count_r - 1'b1;
  assign top_idx  = count_m1[IDX_W-1:0];

  assign cmd.ins     = accept && (in_opcode == OP_INSERT) && !dup && !full;
  assign cmd.pop_min = accept && (in_opcode == OP_POP_MIN) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic   occ;
    logic   left_ge;
    entry_t left_entry;
    entry_t right_entry;

    assign occ = (count_r > IDX);

    if (i == 0) begin : g_first
      assign left_ge    = 1'b0;
      assign left_entry = new_entry;
    end else begin : g_mid
      assign left_ge    = ge_v[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_body
      assign right_entry = cell_entry[i+1];
    end

    mmpq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .new_entry   (new_entry),
      .occ         (occ),
      .left_ge     (left_ge),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .ge          (ge_v[i]),
      .eq          (eq_v[i]),
      .entry       (cell_entry[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (accept && !empty &&
                 ((in_opcode == OP_POP_MAX) || (in_opcode == OP_POP_MIN))) begin
      count_nxt = count_m1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    status_nxt = status_r;
    client_nxt = client_r;
    prio_nxt   = prio_r;
    if (accept) begin
      status_nxt = ST_EMPTY;
      client_nxt = '0;
      prio_nxt   = '0;
      case (in_opcode)
        OP_INSERT: begin
          if (dup) begin
            status_nxt = ST_DUPLICATE;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt = ST_INSERTED;
          end
        end
        OP_POP_MAX: begin
          if (!empty) begin
            status_nxt = ST_POPPED;
            client_nxt = cell_entry[top_idx].client;
            prio_nxt   = cell_entry[top_idx].prio;
          end
        end
        OP_POP_MIN: begin
          if (!empty) begin
            status_nxt = ST_POPPED;
            client_nxt = cell_entry[0].client;
            prio_nxt   = cell_entry[0].prio;
          end
        end
        default: begin
          status_nxt = ST_EMPTY;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    client_r <= client_nxt;
    prio_r   <= prio_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_popped_client   = client_r;
  assign out_popped_priority = prio_r;

endmodule

### design/mmpq_cell.sv
// One sorted slot of the queue: compares the broadcast key and shifts with its neighbours.
module mmpq_cell (
  input  logic                clk,
  input  mmpq_pkg::cell_cmd_t cmd,
  input  mmpq_pkg::entry_t    new_entry,
  input  logic                occ,
  input  logic                left_ge,
  input  mmpq_pkg::entry_t    left_entry,
  input  mmpq_pkg::entry_t    right_entry,
  output logic                ge,
  output logic                eq,
  output mmpq_pkg::entry_t    entry
);
  import mmpq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  assign ge    = !occ || (entry_r.prio > new_entry.prio);
  assign eq    = occ && (entry_r.prio == new_entry.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins && ge) begin
      entry_nxt = left_ge ? left_entry : new_entry;
    end else if (cmd.pop_min) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
